@@ sv/atsw_pkg.sv @@
package atsw_pkg;

    localparam int MAX_SPAN  = 128;
    localparam int DEST_BITS = 16;
    localparam int LEFT_W    = $clog2(MAX_SPAN + 1);

    localparam int ACC_W   = 24;
    localparam int TEXEL_W = 19;
    localparam int BASE_W  = 17;
    localparam int MODE_W  = 2;
    localparam int PIX_W   = 16;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 56;

    typedef enum logic {
        FUNC_SELECT = 1'b0,
        FUNC_SPAN   = 1'b1
    } func_t;

    // State handed to the pair unit for one step.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [MODE_W-1:0] mode;
        logic              col;
        logic              pix_odd;
        logic [ACC_W-1:0]  u;
        logic [ACC_W-1:0]  v;
        logic [ACC_W-1:0]  du;
        logic [ACC_W-1:0]  dv;
        logic [ACC_W-1:0]  du2;
        logic [ACC_W-1:0]  dv2;
        logic [LEFT_W-1:0] left;
    } pair_in_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel_first;
        logic [TEXEL_W-1:0] texel_second;
        logic [ACC_W-1:0]   u_next;
        logic [ACC_W-1:0]   v_next;
        logic               has_second;
        logic [LEFT_W-1:0]  left_next;
    } pair_out_t;

    // Bank-select pattern: row is the blend mode, column is 2*column parity + pixel parity.
    function automatic logic bank_bit(input logic [MODE_W-1:0] mode, input logic [1:0] sel);
        logic [3:0] row;
        begin
            case (mode)
                2'd0:    row = 4'b0000;
                2'd1:    row = 4'b0001;
                2'd2:    row = 4'b1001;
                2'd3:    row = 4'b1011;
                default: row = 4'b0000;
            endcase
            bank_bit = row[sel];
        end
    endfunction

    function automatic logic [TEXEL_W-1:0] texel_addr(
        input logic [BASE_W-1:0] base,
        input logic              bank,
        input logic [ACC_W-1:0]  u,
        input logic [ACC_W-1:0]  v
    );
        logic [TEXEL_W-1:0] ofs;
        begin
            ofs = {{(TEXEL_W - BASE_W - 1){1'b0}}, bank, {(BASE_W - 16){1'b0}},
                   v[23:16], u[23:16]};
            texel_addr = TEXEL_W'(base) + ofs;
        end
    endfunction

endpackage

@@ sv/atsw_pair_unit.sv @@
module atsw_pair_unit (
    input  atsw_pkg::pair_in_t  pin,
    output atsw_pkg::pair_out_t pout
);

    logic [atsw_pkg::ACC_W-1:0] u_mid;
    logic [atsw_pkg::ACC_W-1:0] v_mid;
    logic                       bank_first;
    logic                       bank_second;

    always_comb begin
        u_mid       = pin.u + pin.du;
        v_mid       = pin.v + pin.dv;
        bank_first  = atsw_pkg::bank_bit(pin.mode, {pin.col, pin.pix_odd});
        bank_second = atsw_pkg::bank_bit(pin.mode, {pin.col, ~pin.pix_odd});

        pout.has_second  = (pin.left >= atsw_pkg::LEFT_W'(2));
        pout.texel_first = atsw_pkg::texel_addr(pin.base, bank_first, pin.u, pin.v);
        if (pout.has_second) begin
            pout.texel_second = atsw_pkg::texel_addr(pin.base, bank_second, u_mid, v_mid);
            pout.u_next       = pin.u + pin.du2;
            pout.v_next       = pin.v + pin.dv2;
            pout.left_next    = pin.left - atsw_pkg::LEFT_W'(2);
        end else begin
            // odd tail: only the first pixel is real
            pout.texel_second = '0;
            pout.u_next       = u_mid;
            pout.v_next       = v_mid;
            pout.left_next    = '0;
        end
    end

endmodule

@@ sv/affine_texture_span_walker.sv @@
// Affine texture span walker. A select item (tuser 0) loads the texture base and blend mode.
// A span item (tuser 1) of N pixels, N saturated to 128 and a length of zero ignored,
// yields ceil(N/2) pixel-pair items, one per cycle while m_tready is high. The pair unit
// forms two texel addresses and advances the U and V accumulators by two steps for each
// full pair. s_tready stays low while a span is walked and rises as the final pair enters
// the output register, so the next item can be taken while that pair still waits. m_tlast
// marks the final pair of a span.
module affine_texture_span_walker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // texture_base, blend_mode, span_length, dest_offset, u_start, v_start, u_step, v_step
    input  logic [127:0] s_tdata,
    // func
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_address, texel_address_first, texel_address_second
    output logic [55:0] m_tdata,
    // second_valid
    output logic        m_tuser,
    output logic        m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;

    logic [atsw_pkg::BASE_W-1:0]    base_reg;
    logic [atsw_pkg::MODE_W-1:0]    mode_reg;
    logic                           col_reg;
    logic [atsw_pkg::DEST_BITS-1:0] pix_reg;
    logic [atsw_pkg::ACC_W-1:0]     u_reg;
    logic [atsw_pkg::ACC_W-1:0]     v_reg;
    logic [atsw_pkg::ACC_W-1:0]     du_reg;
    logic [atsw_pkg::ACC_W-1:0]     dv_reg;
    logic [atsw_pkg::ACC_W-1:0]     du2_reg;
    logic [atsw_pkg::ACC_W-1:0]     dv2_reg;
    logic [atsw_pkg::LEFT_W-1:0]    left_reg;

    logic                           m_valid_reg;
    logic [55:0]                    m_data_reg;
    logic                           m_second_reg;
    logic                           m_last_reg;

    logic [atsw_pkg::BASE_W-1:0] in_base;
    logic [atsw_pkg::MODE_W-1:0] in_mode;
    logic [7:0]                  in_len;
    logic [15:0]                 in_dest;
    logic [15:0]                 in_u;
    logic [15:0]                 in_v;
    logic [atsw_pkg::ACC_W-1:0]  in_du;
    logic [atsw_pkg::ACC_W-1:0]  in_dv;
    logic [atsw_pkg::LEFT_W-1:0] len_sat;

    logic s_fire;
    logic out_free;
    logic step;

    atsw_pkg::pair_in_t  pin;
    atsw_pkg::pair_out_t pout;

    assign in_base = s_tdata[16:0];
    assign in_mode = s_tdata[18:17];
    assign in_len  = s_tdata[26:19];
    assign in_dest = s_tdata[42:27];
    assign in_u    = s_tdata[58:43];
    assign in_v    = s_tdata[74:59];
    assign in_du   = s_tdata[98:75];
    assign in_dv   = s_tdata[122:99];

    assign len_sat = (in_len > 8'(atsw_pkg::MAX_SPAN)) ? atsw_pkg::LEFT_W'(atsw_pkg::MAX_SPAN)
                                                       : atsw_pkg::LEFT_W'(in_len);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign step     = (state_reg == ST_RUN) && out_free;

    always_comb begin
        pin.base    = base_reg;
        pin.mode    = mode_reg;
        pin.col     = col_reg;
        pin.pix_odd = pix_reg[0];
        pin.u       = u_reg;
        pin.v       = v_reg;
        pin.du      = du_reg;
        pin.dv      = dv_reg;
        pin.du2     = du2_reg;
        pin.dv2     = dv2_reg;
        pin.left    = left_reg;
    end

    atsw_pair_unit u_pair (
        .pin  (pin),
        .pout (pout)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            mode_reg    <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !step) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (atsw_pkg::func_t'(s_tuser) == atsw_pkg::FUNC_SELECT) begin
                            base_reg <= in_base;
                            mode_reg <= in_mode;
                        end else if (in_len != 8'd0) begin
                            // load the walk; accumulators hold 8.16 positions
                            col_reg   <= in_dest[7];
                            pix_reg   <= atsw_pkg::DEST_BITS'(in_dest);
                            u_reg     <= {in_u, 8'h00};
                            v_reg     <= {in_v, 8'h00};
                            du_reg    <= in_du;
                            dv_reg    <= in_dv;
                            du2_reg   <= {in_du[atsw_pkg::ACC_W-2:0], 1'b0};
                            dv2_reg   <= {in_dv[atsw_pkg::ACC_W-2:0], 1'b0};
                            left_reg  <= len_sat;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (step) begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= {2'b00, pout.texel_second, pout.texel_first,
                                         16'(pix_reg)};
                        m_second_reg <= pout.has_second;
                        m_last_reg   <= (pout.left_next == '0);
                        u_reg        <= pout.u_next;
                        v_reg        <= pout.v_next;
                        pix_reg      <= pix_reg + atsw_pkg::DEST_BITS'(2);
                        left_reg     <= pout.left_next;
                        if (pout.left_next == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_second_reg;
    assign m_tlast  = m_last_reg;

    a_span_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser && in_len != 8'd0) |=> (state_reg == ST_RUN))
        else $error("span item did not start a walk");

    a_run_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (left_reg != '0 &&
                                   left_reg <= atsw_pkg::LEFT_W'(atsw_pkg::MAX_SPAN)))
        else $error("pixel count out of range while walking");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pout.left_next == '0) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final pair did not end the walk");

    a_pair_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pout.left_next != '0) |=> (m_tvalid && !m_tlast && m_tuser))
        else $error("inner pair lost its second pixel or was marked last");

endmodule

@@ tb/affine_texture_span_walker_tb.sv @@
module affine_texture_span_walker_tb;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // texture_base, blend_mode, span_length, dest_offset, u_start, v_start, u_step, v_step
    logic [127:0] s_tdata;
    // func
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // pixel_address, texel_address_first, texel_address_second
    logic [55:0]  m_tdata;
    // second_valid
    logic         m_tuser;
    logic         m_tlast;

    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    int unsigned items_taken = 0;

    typedef struct packed {
        logic [atsw_pkg::PIX_W-1:0]   pix;
        logic [atsw_pkg::TEXEL_W-1:0] texel_first;
        logic [atsw_pkg::TEXEL_W-1:0] texel_second;
        logic                         second;
        logic                         last;
    } pixel_pair_t;

    class pair_scoreboard;
        // bit n of a row is the bank choice for {column parity, pixel parity} = n
        bit [3:0]                     bank_rows [4] = '{4'b0000, 4'b0001, 4'b1001, 4'b1011};
        logic [atsw_pkg::BASE_W-1:0]  base;
        logic [atsw_pkg::MODE_W-1:0]  mode;
        logic [atsw_pkg::ACC_W-1:0]   u_acc;
        logic [atsw_pkg::ACC_W-1:0]   v_acc;
        pixel_pair_t                  expected_pairs [$];
        int unsigned                  errors;

        function new();
            base = '0;
            mode = '0;
            u_acc = '0;
            v_acc = '0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        // Texel address of one pixel, then advance both accumulators.
        function logic [atsw_pkg::TEXEL_W-1:0] texel_for_pixel(logic col, logic pix_odd,
                                                    logic [atsw_pkg::ACC_W-1:0] du,
                                                    logic [atsw_pkg::ACC_W-1:0] dv);
            logic                         bank;
            logic [atsw_pkg::TEXEL_W-1:0] ofs;
            bank = bank_rows[mode][{col, pix_odd}];
            ofs = {1'b0, bank, 1'b0, v_acc[23:16], u_acc[23:16]};
            u_acc = u_acc + du;
            v_acc = v_acc + dv;
            return {2'b00, base} + ofs;
        endfunction

        function void note_command(atsw_pkg::func_t func, logic [127:0] data);
            logic [8:0]                 left;
            logic [atsw_pkg::PIX_W-1:0] pix;
            logic                       col;
            logic [atsw_pkg::ACC_W-1:0] du;
            logic [atsw_pkg::ACC_W-1:0] dv;
            pixel_pair_t                p;
            if (func == atsw_pkg::FUNC_SELECT) begin
                base = data[16:0];
                mode = data[18:17];
                return;
            end
            left = {1'b0, data[26:19]};
            if (left == 9'd0)
                return;
            if (left > 9'(atsw_pkg::MAX_SPAN))
                left = 9'(atsw_pkg::MAX_SPAN);
            pix = data[42:27];
            col = pix[7];
            u_acc = {data[58:43], 8'h00};
            v_acc = {data[74:59], 8'h00};
            du = data[98:75];
            dv = data[122:99];
            while (left > 9'd0) begin
                p.pix = pix;
                p.texel_first = texel_for_pixel(col, pix[0], du, dv);
                pix = pix + 1'b1;
                if (left >= 9'd2) begin
                    p.texel_second = texel_for_pixel(col, pix[0], du, dv);
                    pix = pix + 1'b1;
                    left = left - 9'd2;
                    p.second = 1'b1;
                end else begin
                    p.texel_second = '0;
                    left = 9'd0;
                    p.second = 1'b0;
                end
                p.last = (left == 9'd0);
                expected_pairs.push_back(p);
            end
        endfunction

        function void check_pair(logic [55:0] data, logic second, logic last);
            pixel_pair_t e;
            if (expected_pairs.size() == 0) begin
                flag($sformatf("unexpected pair: pix %h texels %h %h second %b last %b",
                               data[15:0], data[34:16], data[53:35], second, last));
                return;
            end
            e = expected_pairs.pop_front();
            if (data[15:0] !== e.pix || data[34:16] !== e.texel_first
                    || data[53:35] !== e.texel_second || second !== e.second
                    || last !== e.last)
                flag($sformatf({"pair mismatch: expected pix %h texels %h %h second %b",
                                " last %b, got pix %h texels %h %h second %b last %b"},
                               e.pix, e.texel_first, e.texel_second, e.second, e.last,
                               data[15:0], data[34:16], data[53:35], second, last));
        endfunction
    endclass

    pair_scoreboard board = new();

    affine_texture_span_walker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [127:0] pack_item(logic [16:0] base, logic [1:0] mode,
                                               logic [7:0] len, logic [15:0] dest,
                                               logic [15:0] u, logic [15:0] v,
                                               logic [23:0] du, logic [23:0] dv);
        return {5'b00000, dv, du, v, u, dest, len, mode, base};
    endfunction

    task automatic send_item(atsw_pkg::func_t func, logic [127:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        board.note_command(func, data);
        items_taken++;
    endtask

    task automatic send_span(logic [7:0] len, logic [15:0] dest, logic [15:0] u,
                             logic [15:0] v, logic [23:0] du, logic [23:0] dv);
        send_item(atsw_pkg::FUNC_SPAN, pack_item($urandom, $urandom, len, dest, u, v, du, dv));
    endtask

    task automatic send_select(logic [16:0] base, logic [1:0] mode);
        send_item(atsw_pkg::FUNC_SELECT, pack_item(base, mode, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom));
    endtask

    // Alternate between spells of random idling and spells with none.
    initial begin
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge aclk);
            calm <= ~calm;
        end
    end

    // Stall the output long enough for the input to back up.
    initial begin
        while (items_taken < 40) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                board.check_pair(m_tdata, m_tuser, m_tlast);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int r;
        int s;
        s_tvalid <= 1'b0;
        s_tuser <= atsw_pkg::FUNC_SELECT;
        s_tdata <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, saturation, ignored spans, odd lengths, wrap, every blend mode
        send_span(8'd1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 24'h000000);
        send_select(17'h1FFFF, 2'd3);
        send_span(8'd128, 16'hFF80, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_span(8'd0, 16'h1234, 16'h5678, 16'h9ABC, 24'h010000, 24'h010000);
        send_span(8'd255, 16'h0080, 16'h0100, 16'h0200, 24'h018000, 24'hFF8000);
        send_span(8'd129, 16'hFFFE, 16'h8000, 16'h4000, 24'h000100, 24'h7FFFFF);
        send_select(17'h00000, 2'd1);
        send_span(8'd4, 16'h007F, 16'h0000, 16'h0000, 24'h010000, 24'h020000);
        send_span(8'd5, 16'h0081, 16'h1000, 16'h2000, 24'h00FFFF, 24'h000001);
        send_select(17'h12345, 2'd2);
        send_span(8'd5, 16'h0081, 16'h1000, 16'h2000, 24'h00FFFF, 24'h000001);
        send_span(8'd6, 16'h0000, 16'hFFFF, 16'h0000, 24'h800000, 24'h800000);
        send_select(17'h1FFFF, 2'd2);
        send_span(8'd7, 16'h00FE, 16'hFFFF, 16'hFFFF, 24'h000000, 24'h000000);
        send_select(17'h0ABCD, 2'd0);
        send_span(8'd2, 16'h8001, 16'h00FF, 16'hFF00, 24'hFFFFFF, 24'h000000);
        send_span(8'd3, 16'hFFFF, 16'h7F7F, 16'h8080, 24'h000000, 24'hFFFFFF);
        send_span(8'd127, 16'h5555, 16'hAAAA, 16'h5555, 24'h555555, 24'hAAAAAA);

        repeat (360) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_select($urandom, $urandom);
            end else begin
                s = $urandom_range(0, 99);
                if (s < 70)
                    r = $urandom_range(1, 24);
                else if (s < 90)
                    r = $urandom_range(25, 128);
                else
                    r = $urandom_range(0, 255);
                if ($urandom_range(0, 1))
                    send_span(r, $urandom, $urandom, $urandom,
                              $urandom_range(0, 24'h03FFFF), $urandom_range(0, 24'h03FFFF));
                else
                    send_span(r, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/atsw_pkg.sv
sv/atsw_pair_unit.sv
sv/affine_texture_span_walker.sv
tb/affine_texture_span_walker_tb.sv
